### rtl/core/bezier_adaptive_flattener_assert.svh
// Assertion macros for the Bezier flattener checker
`ifndef BEZIER_ADAPTIVE_FLATTENER_ASSERT_SVH
`define BEZIER_ADAPTIVE_FLATTENER_ASSERT_SVH
// a implies b on the next cycle
`define BAF_ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
// a implies b in the same cycle
`define BAF_ASSERT_NOW(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`endif

### rtl/core/baf_pkg.sv
// Types and constants shared by the Bezier flattener
package baf_pkg;
  localparam int CoordW = 16;
  localparam int TolW = 16;
  localparam int StackDepth = 6;
  localparam int LevelW = 3;

  typedef struct packed {
    logic signed [CoordW-1:0] start_x;
    logic signed [CoordW-1:0] start_y;
    logic signed [CoordW-1:0] out_x;
    logic signed [CoordW-1:0] out_y;
    logic signed [CoordW-1:0] in_x;
    logic signed [CoordW-1:0] in_y;
    logic signed [CoordW-1:0] end_x;
    logic signed [CoordW-1:0] end_y;
    logic first_of_path;
  } seg_in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic last;
  } point_out_t;
endpackage

### rtl/core/baf_ram.sv
// Generic single-port-write, registered-read RAM
module baf_ram #(
  parameter int Width = 8,
  parameter int Depth = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/core/bezier_adaptive_flattener.sv
// Adaptive cubic Bezier flattener: top level with subdivision stack in RAM
// The optional start point leaves from S_START, each end point from S_EMIT after the flatness test.
// Each node passes through products, squares and decide (S_MUL1, S_MUL2, S_DEC); a flat
// node then emits and, unless it is the last, reads the stack RAM (S_POP, S_LOAD).
// Output stalls hold the emit. One segment at a time: in_ready is high only in idle.
// Reset (rst, synchronous): control returns to idle, tolerance reloads 256.
module bezier_adaptive_flattener
  import baf_pkg::*;
#(
  parameter int MAX_DEPTH = 5
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  seg_in_t    in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output point_out_t out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [TolW-1:0] cfg_data
);
  localparam int SW = 4 * CoordW;      // one half of a piece
  localparam int AW = $clog2(StackDepth);
  localparam int PW = 2 * CoordW + 2;  // cross product width
  localparam int QW = 2 * PW + 2;      // squared sum width

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL1  = 3'd1;
  localparam logic [2:0] S_MUL2  = 3'd2;
  localparam logic [2:0] S_DEC   = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;
  localparam logic [2:0] S_POP   = 3'd5;
  localparam logic [2:0] S_LOAD  = 3'd6;
  localparam logic [2:0] S_START = 3'd7;

  logic [2:0] state;
  logic [TolW-1:0] tol;
  logic signed [CoordW-1:0] cx [4];
  logic signed [CoordW-1:0] cy [4];
  logic [LevelW-1:0] level;
  logic [AW:0] sp;
  logic first_pend;

  // stage registers of the flatness test
  logic signed [PW-1:0] d2, d3;
  logic [PW:0] chord;
  logic [QW-1:0] lhs, rhs;
  logic degen;

  // ---- stack RAMs: front (start, out), back (in, end), level ----
  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [SW-1:0] fw, bw, fr, br;
  logic [LevelW-1:0] lw, lr;

  baf_ram #(.Width(SW), .Depth(StackDepth)) u_front (
    .clk(clk), .we(we), .waddr(waddr), .wdata(fw), .raddr(raddr), .rdata(fr));
  baf_ram #(.Width(SW), .Depth(StackDepth)) u_back (
    .clk(clk), .we(we), .waddr(waddr), .wdata(bw), .raddr(raddr), .rdata(br));
  baf_ram #(.Width(LevelW), .Depth(StackDepth)) u_lvl (
    .clk(clk), .we(we), .waddr(waddr), .wdata(lw), .raddr(raddr), .rdata(lr));

  // ---- de Casteljau split, floor midpoints ----
  function automatic logic signed [CoordW-1:0] mid(logic signed [CoordW-1:0] a,
                                                   logic signed [CoordW-1:0] b);
    logic signed [CoordW:0] s;
    s = {a[CoordW-1], a} + {b[CoordW-1], b};
    return s[CoordW:1];
  endfunction

  logic signed [CoordW-1:0] ax, bx, ccx, dx_, ex, fx;
  logic signed [CoordW-1:0] ay, by, ccy, dy_, ey, fy;
  always_comb begin
    ax = mid(cx[0], cx[1]); bx = mid(cx[1], cx[2]); ccx = mid(cx[2], cx[3]);
    dx_ = mid(ax, bx); ex = mid(bx, ccx); fx = mid(dx_, ex);
    ay = mid(cy[0], cy[1]); by = mid(cy[1], cy[2]); ccy = mid(cy[2], cy[3]);
    dy_ = mid(ay, by); ey = mid(by, ccy); fy = mid(dy_, ey);
  end

  // push the right half when splitting
  logic split;
  assign split = (state == S_DEC) && !(level >= LevelW'(MAX_DEPTH) || degen || lhs <= rhs);
  assign we = split && (sp < (AW+1)'(StackDepth));
  assign waddr = sp[AW-1:0];
  assign fw = {fx, fy, ex, ey};
  assign bw = {ccx, ccy, cx[3], cy[3]};
  assign lw = level + 1'b1;
  assign raddr = sp[AW-1:0] - 1'b1;

  // ---- chord and cross products (first stage) ----
  logic signed [CoordW:0] chx, chy, h1x, h1y, h2x, h2y;
  assign chx = {cx[3][CoordW-1], cx[3]} - {cx[0][CoordW-1], cx[0]};
  assign chy = {cy[3][CoordW-1], cy[3]} - {cy[0][CoordW-1], cy[0]};
  assign h1x = {cx[1][CoordW-1], cx[1]} - {cx[3][CoordW-1], cx[3]};
  assign h1y = {cy[1][CoordW-1], cy[1]} - {cy[3][CoordW-1], cy[3]};
  assign h2x = {cx[2][CoordW-1], cx[2]} - {cx[3][CoordW-1], cx[3]};
  assign h2y = {cy[2][CoordW-1], cy[2]} - {cy[3][CoordW-1], cy[3]};

  // ---- magnitudes and their sum (second stage) ----
  logic [PW-1:0] a2, a3;
  logic [PW:0] ssum;
  assign a2 = d2[PW-1] ? PW'(-d2) : d2;
  assign a3 = d3[PW-1] ? PW'(-d3) : d3;
  assign ssum = (PW+1)'(a2) + (PW+1)'(a3);

  // a point leaves when the output register is free or being emptied
  logic emit_fire;
  assign emit_fire = ((state == S_START && first_pend) || state == S_EMIT) &&
                     (!out_valid || out_ready);

  assign in_ready = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE) && !in_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      tol <= TolW'(256);
      out_valid <= 1'b0;
      sp <= '0;
    end else begin
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) tol <= cfg_data;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cx[0] <= in_data.start_x; cy[0] <= in_data.start_y;
            cx[1] <= in_data.out_x;   cy[1] <= in_data.out_y;
            cx[2] <= in_data.in_x;    cy[2] <= in_data.in_y;
            cx[3] <= in_data.end_x;   cy[3] <= in_data.end_y;
            first_pend <= in_data.first_of_path;
            level <= '0;
            sp <= '0;
            state <= S_START;
          end
        end
        S_START: begin
          // optional start point
          if (!first_pend) begin
            state <= S_MUL1;
          end else if (emit_fire) begin
            out_data <= '{point_x: cx[0], point_y: cy[0], last: 1'b0};
            first_pend <= 1'b0;
            state <= S_MUL1;
          end
        end
        S_MUL1: begin
          degen <= cx[0] == cx[1] && cy[0] == cy[1] && cx[2] == cx[3] && cy[2] == cy[3];
          d2 <= PW'(h1x * chy) - PW'(h1y * chx);
          d3 <= PW'(h2x * chy) - PW'(h2y * chx);
          chord <= (PW+1)'($unsigned(PW'(chx * chx))) + (PW+1)'($unsigned(PW'(chy * chy)));
          state <= S_MUL2;
        end
        S_MUL2: begin
          // both sides of the flatness compare
          lhs <= QW'(ssum) * QW'(ssum);
          rhs <= QW'(tol) * QW'(chord);
          state <= S_DEC;
        end
        S_DEC: begin
          if (split) begin
            cx[1] <= ax; cx[2] <= dx_; cx[3] <= fx;
            cy[1] <= ay; cy[2] <= dy_; cy[3] <= fy;
            level <= level + 1'b1;
            if (we) sp <= sp + 1'b1;
            state <= S_MUL1;
          end else begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_fire) begin
            out_data <= '{point_x: cx[3], point_y: cy[3], last: (sp == '0)};
            state <= (sp == '0) ? S_IDLE : S_POP;
          end
        end
        S_POP: begin
          state <= S_LOAD; // RAM read in flight
        end
        S_LOAD: begin
          {cx[0], cy[0], cx[1], cy[1]} <= fr;
          {cx[2], cy[2], cx[3], cy[3]} <= br;
          level <= lr;
          sp <= sp - 1'b1;
          state <= S_MUL1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### rtl/core/baf_checker.sv
// Port-level checker for the Bezier flattener, bound to the top level
`include "bezier_adaptive_flattener_assert.svh"
module baf_checker
  import baf_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input point_out_t out_data,
  input logic       cfg_ready
);
  `BAF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `BAF_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `BAF_ASSERT_NOW(a_cfg_idle, cfg_ready, in_ready)
endmodule

bind bezier_adaptive_flattener baf_checker u_baf_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
  .cfg_ready(cfg_ready));

### test/bezier_adaptive_flattener_checker.sv
// Checker for the Bezier flattener: predicts polyline points and compares transfers
module bezier_adaptive_flattener_checker
  import baf_pkg::*;
#(
  parameter int MAX_DEPTH = 5
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_ready,
  input  seg_in_t         in_data,
  input  logic            out_valid,
  input  logic            out_ready,
  input  point_out_t      out_data,
  input  logic            cfg_valid,
  input  logic            cfg_ready,
  input  logic [TolW-1:0] cfg_data,
  output int              fail_count,
  output int              pending_points
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    longint x[4];
    longint y[4];
    int     lvl;
  } piece_t;

  point_out_t expected_points[$];
  logic [TolW-1:0] tolerance;

  function automatic logic piece_is_flat(piece_t p, logic [TolW-1:0] tol);
    longint dx, dy, c2, c3;
    logic [127:0] lhs, rhs, s, chord;
    if (p.x[0] == p.x[1] && p.y[0] == p.y[1] && p.x[2] == p.x[3] && p.y[2] == p.y[3])
      return 1'b1;
    dx = p.x[3] - p.x[0];
    dy = p.y[3] - p.y[0];
    c2 = (p.x[1] - p.x[3]) * dy - (p.y[1] - p.y[3]) * dx;
    c3 = (p.x[2] - p.x[3]) * dy - (p.y[2] - p.y[3]) * dx;
    if (c2 < 0) c2 = -c2;
    if (c3 < 0) c3 = -c3;
    s = 128'(c2) + 128'(c3);
    chord = 128'(dx * dx) + 128'(dy * dy);
    lhs = s * s;
    rhs = 128'(tol) * chord;
    return lhs <= rhs;
  endfunction

  // floor average, arithmetic shift
  function automatic longint avg(longint a, longint b);
    return (a + b) >>> 1;
  endfunction

  function automatic void push_point(longint x, longint y);
    point_out_t pt;
    pt.point_x = x[CoordW-1:0];
    pt.point_y = y[CoordW-1:0];
    pt.last = 1'b0;
    expected_points.insert(expected_points.size(), pt);
  endfunction

  // Depth-first flattening of one segment into expected_points
  function automatic void flatten_segment(seg_in_t seg);
    piece_t cur, lp, rp;
    piece_t stack[$];
    longint c[4], a, b, cc, d, e, f;
    cur.x[0] = seg.start_x; cur.y[0] = seg.start_y;
    cur.x[1] = seg.out_x;   cur.y[1] = seg.out_y;
    cur.x[2] = seg.in_x;    cur.y[2] = seg.in_y;
    cur.x[3] = seg.end_x;   cur.y[3] = seg.end_y;
    cur.lvl = 0;
    if (seg.first_of_path) push_point(cur.x[0], cur.y[0]);
    forever begin
      if (cur.lvl >= MAX_DEPTH || piece_is_flat(cur, tolerance)) begin
        push_point(cur.x[3], cur.y[3]);
        if (stack.size() == 0) break;
        cur = stack.pop_back();
      end else begin
        for (int k = 0; k < 2; k++) begin
          for (int j = 0; j < 4; j++) c[j] = (k == 0) ? cur.x[j] : cur.y[j];
          a = avg(c[0], c[1]); b = avg(c[1], c[2]); cc = avg(c[2], c[3]);
          d = avg(a, b); e = avg(b, cc); f = avg(d, e);
          if (k == 0) begin
            lp.x = '{c[0], a, d, f}; rp.x = '{f, e, cc, c[3]};
          end else begin
            lp.y = '{c[0], a, d, f}; rp.y = '{f, e, cc, c[3]};
          end
        end
        lp.lvl = cur.lvl + 1;
        rp.lvl = cur.lvl + 1;
        stack.insert(stack.size(), rp);
        cur = lp;
      end
    end
    expected_points[expected_points.size() - 1].last = 1'b1;
  endfunction

  always @(posedge clk) begin
    point_out_t want;
    if (rst) begin
      tolerance <= 16'd256;
      fail_count <= 0;
      expected_points.delete();
    end else begin
      if (cfg_valid && cfg_ready) tolerance <= cfg_data;
      if (in_valid && in_ready) flatten_segment(in_data);
      if (out_valid && out_ready) begin
        if (expected_points.size() == 0) begin
          $display("%0t: unexpected point x=%0d y=%0d last=%0b", $time,
                   out_data.point_x, out_data.point_y, out_data.last);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_points.pop_front();
          if (want != out_data) begin
            $display("%0t: point mismatch expected x=%0d y=%0d last=%0b",
                     $time, want.point_x, want.point_y, want.last,
                     " actual x=%0d y=%0d last=%0b",
                     out_data.point_x, out_data.point_y, out_data.last);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending_points <= expected_points.size();
  end
endmodule

### test/bezier_adaptive_flattener_test.sv
// Testbench top for the Bezier flattener: stimulus, stalls and verdict
module bezier_adaptive_flattener_test;
  import baf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            in_valid = 1'b0;
  logic            in_ready;
  seg_in_t         in_data = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  point_out_t      out_data;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [TolW-1:0] cfg_data = '0;
  int              fail_count;
  int              pending_points;
  logic            hold_off = 1'b0;  // forces a long receiver stall

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bezier_adaptive_flattener u_dut (
    .clk, .rst, .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data,
    .cfg_valid, .cfg_ready, .cfg_data
  );

  bezier_adaptive_flattener_checker u_checker (
    .clk, .rst, .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data,
    .cfg_valid, .cfg_ready, .cfg_data,
    .fail_count, .pending_points
  );

  // Random 16-bit coordinate; extremes show up often
  function automatic logic [CoordW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  // Send one segment; optionally sit idle first
  task automatic send_segment(seg_in_t seg, logic with_gap);
    int gap;
    gap = with_gap ? $urandom_range(0, 10) : 0;
    @(posedge clk);
    repeat (gap) @(posedge clk);
    in_valid <= 1'b1;
    in_data  <= seg;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic seg_of(output seg_in_t seg, input int sx, sy, ox, oy, ix, iy, ex, ey,
                        input logic fop);
    seg.start_x = 16'(sx); seg.start_y = 16'(sy);
    seg.out_x = 16'(ox);   seg.out_y = 16'(oy);
    seg.in_x = 16'(ix);    seg.in_y = 16'(iy);
    seg.end_x = 16'(ex);   seg.end_y = 16'(ey);
    seg.first_of_path = fop;
  endtask

  // Wait until every predicted point has been transferred
  task automatic drain();
    @(posedge clk);
    while (pending_points != 0) @(posedge clk);
  endtask

  // Drain, let the block settle, then write the tolerance
  task automatic set_tolerance(logic [TolW-1:0] tol);
    drain();
    repeat (20) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= tol;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: random stall per point, with a long hold-off on request
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if (stall != 0 || hold_off) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
        while (hold_off) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    seg_in_t seg;
    logic [TolW-1:0] tol_set[4];
    tol_set = '{16'd0, 16'hffff, 16'd16, 16'd4096};
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: default tolerance
    seg_of(seg, 0, 0, 0, 0, 160, 160, 160, 160, 1'b1); send_segment(seg, 1'b0);  // degenerate
    seg_of(seg, 5, 5, 5, 5, 5, 5, 5, 5, 1'b0); send_segment(seg, 1'b0);  // all one point
    seg_of(seg, 0, 0, 100, 900, -50, 900, 0, 0, 1'b1); send_segment(seg, 1'b0);  // zero chord
    seg_of(seg, 0, 0, 10, 0, 20, 0, 30, 0, 1'b0); send_segment(seg, 1'b0);  // straight
    seg_of(seg, -32768, -32768, -32768, 32767, 32767, -32768, 32767, 32767, 1'b1);
    send_segment(seg, 1'b0);  // widest curve, hits depth cap
    seg_of(seg, 32767, 32767, -32768, -32768, 32767, 32767, -32768, -32768, 1'b1);
    send_segment(seg, 1'b0);
    seg_of(seg, -1, -1, -32768, 0, 0, 32767, 1, 1, 1'b0); send_segment(seg, 1'b0);
    seg_of(seg, 0, 0, 0, 64, 64, 64, 64, 0, 1'b1); send_segment(seg, 1'b0);

    // long receiver hold-off so the block backs up its input
    hold_off <= 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_off <= 1'b0;
      end
      for (int i = 0; i < 6; i++) begin
        seg_of(seg, 0, 0, 300, 800, 700, -800, 1000, 0, i[0]);
        send_segment(seg, 1'b0);
      end
    join

    // sender waits for a full drain
    drain();

    // random phases across tolerance settings, extremes included
    for (int ph = 0; ph < 5; ph++) begin
      set_tolerance(ph < 4 ? tol_set[ph] : 16'($urandom));
      for (int i = 0; i < 30; i++) begin
        if ($urandom_range(0, 2) == 0) begin
          for (int j = 0; j < 8; j++) seg[j*16+1 +: 16] = rand_coord();
          seg.first_of_path = $urandom_range(0, 1);
        end else begin
          // small curves keep the point count varied
          seg_of(seg, $urandom_range(0, 400) - 200, $urandom_range(0, 400) - 200,
                 $urandom_range(0, 400) - 200, $urandom_range(0, 400) - 200,
                 $urandom_range(0, 400) - 200, $urandom_range(0, 400) - 200,
                 $urandom_range(0, 400) - 200, $urandom_range(0, 400) - 200,
                 $urandom_range(0, 1));
        end
        send_segment(seg, $urandom_range(0, 4) != 0);
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending_points == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end
endmodule
